// ===== rtl/swf_pkg.sv =====
package swf_pkg;

    localparam int unsigned SYNC_LEN = 5;

    typedef enum logic [2:0] {
        PH_HUNT0   = 3'd0,
        PH_HUNT1   = 3'd1,
        PH_HUNT2   = 3'd2,
        PH_HUNT3   = 3'd3,
        PH_HUNT4   = 3'd4,
        PH_TYPE    = 3'd5,
        PH_LENGTH  = 3'd6,
        PH_PAYLOAD = 3'd7
    } t_phase;

    typedef enum logic {
        FUNC_BYTE  = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    localparam logic [7:0] SYNC_B0 = 8'h57;  // W
    localparam logic [7:0] SYNC_B1 = 8'h41;  // A
    localparam logic [7:0] SYNC_B2 = 8'h4C;  // L
    localparam logic [7:0] SYNC_B3 = 8'h44;  // D
    localparam logic [7:0] SYNC_B4 = 8'h4F;  // O

    function automatic logic [7:0] sync_byte(input t_phase phase);
        logic [7:0] b;
        unique case (phase)
            PH_HUNT0: b = SYNC_B0;
            PH_HUNT1: b = SYNC_B1;
            PH_HUNT2: b = SYNC_B2;
            PH_HUNT3: b = SYNC_B3;
            PH_HUNT4: b = SYNC_B4;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sync_word_frame_deframer.sv =====
// Sync word deframer for a received byte stream.
// Slave channel: one received byte per transaction on s_axis_tdata; s_axis_tuser
// set means clear, which drops any partial frame and restarts the sync hunt.
// Master channel: one result per payload byte, carrying the frame's type byte,
// the payload byte and the declared length in m_axis_tdata; m_axis_tuser is
// set when a payload byte is present and clear for the single result of a
// zero-length frame; m_axis_tlast marks the final result of a frame.
// Sync bytes, the type byte and a nonzero length byte give no result.
// A result is registered: it appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle while no result waits on m_axis_tready, set by
// the single output register; the phase update is done in the same cycle the byte is accepted.
// Stall: while a result waits on m_axis_tready, s_axis_tready follows
// m_axis_tready, so a byte is taken in the same cycle the waiting result leaves.
// Reset: synchronous, active low; returns to hunting the first sync byte,
// clears the held type and length and empties the output register.
module sync_word_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // cmd_type, payload_byte, payload_length
    output logic [0:0]  m_axis_tuser,   // payload_present
    output logic        m_axis_tlast    // frame_last
);

    swf_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_type, n_type;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_rem, n_rem;

    logic            r_m_valid, n_m_valid;
    logic [7:0]      r_o_type, n_o_type;
    logic [7:0]      r_o_byte, n_o_byte;
    logic [7:0]      r_o_len, n_o_len;
    logic            r_o_present, n_o_present;
    logic            r_o_last, n_o_last;

    logic            accept;
    logic            emit;
    logic [7:0]      rem_dec;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rem_dec       = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= swf_pkg::PH_HUNT0;
            r_type    <= 8'd0;
            r_len     <= 8'd0;
            r_rem     <= 8'd0;
            r_m_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_type    <= n_o_type;
            r_o_byte    <= n_o_byte;
            r_o_len     <= n_o_len;
            r_o_present <= n_o_present;
            r_o_last    <= n_o_last;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_rem       = r_rem;
        emit        = 1'b0;
        n_o_byte    = 8'd0;
        n_o_present = 1'b0;
        n_o_last    = 1'b0;
        if (accept) begin
            if (swf_pkg::t_func'(s_axis_tuser[0]) == swf_pkg::FUNC_CLEAR) begin
                n_phase = swf_pkg::PH_HUNT0;
                n_type  = 8'd0;
                n_len   = 8'd0;
                n_rem   = 8'd0;
            end else begin
                unique case (r_phase)
                    swf_pkg::PH_HUNT0, swf_pkg::PH_HUNT1, swf_pkg::PH_HUNT2,
                    swf_pkg::PH_HUNT3, swf_pkg::PH_HUNT4: begin
                        if (s_axis_tdata == swf_pkg::sync_byte(r_phase)) begin
                            n_phase = swf_pkg::t_phase'(r_phase + 3'd1);
                        end else if (s_axis_tdata == swf_pkg::SYNC_B0) begin
                            n_phase = swf_pkg::PH_HUNT1;
                        end else begin
                            n_phase = swf_pkg::PH_HUNT0;
                        end
                    end
                    swf_pkg::PH_TYPE: begin
                        n_type  = s_axis_tdata;
                        n_phase = swf_pkg::PH_LENGTH;
                    end
                    swf_pkg::PH_LENGTH: begin
                        n_len = s_axis_tdata;
                        n_rem = s_axis_tdata;
                        if (s_axis_tdata == 8'd0) begin
                            n_phase  = swf_pkg::PH_HUNT0;
                            emit     = 1'b1;
                            n_o_last = 1'b1;
                        end else begin
                            n_phase = swf_pkg::PH_PAYLOAD;
                        end
                    end
                    swf_pkg::PH_PAYLOAD: begin
                        n_rem       = rem_dec;
                        emit        = 1'b1;
                        n_o_byte    = s_axis_tdata;
                        n_o_present = 1'b1;
                        n_o_last    = (rem_dec == 8'd0);
                        if (rem_dec == 8'd0) begin
                            n_phase = swf_pkg::PH_HUNT0;
                        end
                    end
                endcase
            end
        end
        n_o_type  = n_type;
        n_o_len   = n_len;
        n_m_valid = emit || (r_m_valid && !m_axis_tready);
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_o_len, r_o_byte, r_o_type};
    assign m_axis_tuser  = r_o_present;
    assign m_axis_tlast  = r_o_last;

endmodule

// ===== rtl/swf_checker.sv =====
module swf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // empty output register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // zero-length result is alone in its frame and carries no byte
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[15:8] == 8'd0)
            && (m_axis_tdata[23:16] == 8'd0))
        else $error("bad empty frame result");

    // a clear transaction produces no result
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0]
            && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
        else $error("result after clear");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sync_word_frame_deframer swf_checker u_swf_checker (.*);
